// ----- rtl/core/scv_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// scv_pkg
// Shared types, constants and the mask arithmetic for the 3x3 sharpening
// convolution block.
// ============================================================================
package scv_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int SIZE_W = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = 2;

    localparam int PIX_MAX = 255;
    localparam int TAPS    = 9;
    localparam int SUM_W   = 13;   // covers -2040 .. +2295
    localparam int COEF_W  = 5;    // coefficients span -2 .. +8

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_MASK   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_cfg_reg;

    // Mask selection codes
    typedef enum logic [1:0] {
        MASK_PASS  = 2'd0,
        MASK_CROSS = 2'd1,
        MASK_EIGHT = 2'd2,
        MASK_THIRD = 2'd3
    } t_mask;

    // 3x3 neighborhood, row-major, tap 0 is upper left
    typedef logic [TAPS-1:0][PIX_W-1:0] t_window;

    // One line buffer word: row above and two rows above
    typedef struct packed {
        logic [PIX_W-1:0] near;
        logic [PIX_W-1:0] far;
    } t_line_word;

    // One result item
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic             last_of_step;
    } t_result;

    // Up to two results written into the queue in one cycle
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    // Mask table; pass-through is the identity mask, which keeps the center
    localparam logic signed [COEF_W-1:0] KERNELS [4][TAPS] = '{
        '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0, 5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
        '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1, 5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
        '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
        '{ 5'sd1, -5'sd2,  5'sd1, -5'sd2, 5'sd5, -5'sd2,  5'sd1, -5'sd2,  5'sd1}
    };

    // Weighted sum of the window, clamped to the pixel range
    function automatic logic [PIX_W-1:0] filter_window(input t_window win,
                                                       input t_mask   mode);
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] pix_s;
        logic signed [SUM_W-1:0] coef_s;
        logic [PIX_W-1:0]        res;
        sum = '0;
        for (int k = 0; k < TAPS; k++) begin
            pix_s  = signed'(SUM_W'(win[k]));
            coef_s = SUM_W'(KERNELS[mode][k]);
            sum    = sum + SUM_W'(pix_s * coef_s);
        end
        if (sum < 0) begin
            res = '0;
        end else if (sum > SUM_W'(PIX_MAX)) begin
            res = PIX_W'(PIX_MAX);
        end else begin
            res = sum[PIX_W-1:0];
        end
        return res;
    endfunction

    // Frame size as used: zero acts as one, large values saturate
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/scv_ifs.sv -----
`timescale 1ns / 1ps
// ============================================================================
// scv_ifs
// Valid/ready channel interfaces: pixel input, result output, register write.
// ============================================================================
interface scv_pix_if;
    logic                      valid;
    logic                      ready;
    logic [scv_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface scv_res_if;
    logic                      valid;
    logic                      ready;
    logic [scv_pkg::PIX_W-1:0] pixel_out;
    logic [scv_pkg::COL_W-1:0] out_col;
    logic [scv_pkg::ROW_W-1:0] out_row;
    logic                      last_of_step;

    modport source (output valid, output pixel_out, output out_col, output out_row,
                    output last_of_step, input ready);
    modport sink   (input valid, input pixel_out, input out_col, input out_row,
                    input last_of_step, output ready);
endinterface

interface scv_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [scv_pkg::ADDR_W-1:0] addr;
    logic [scv_pkg::SIZE_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- rtl/core/scv_line_buf.sv -----
`timescale 1ns / 1ps
// ============================================================================
// scv_line_buf
// Two-row line buffer: one word per column holds the row above and the row
// two above. Registered read, one write port.
// ============================================================================
module scv_line_buf (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [scv_pkg::COL_W-1:0] i_rd_addr,
    output scv_pkg::t_line_word       o_rd_data,
    input  logic                      i_wr_en,
    input  logic [scv_pkg::COL_W-1:0] i_wr_addr,
    input  scv_pkg::t_line_word       i_wr_data
);

    scv_pkg::t_line_word r_mem [scv_pkg::MAX_WIDTH];
    scv_pkg::t_line_word r_rd_data;

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/scv_out_fifo.sv -----
`timescale 1ns / 1ps
// ============================================================================
// scv_out_fifo
// Result queue: takes up to two results per cycle, hands out one.
// ============================================================================
module scv_out_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  scv_pkg::t_push            i_push,
    input  logic                      i_pop,
    output scv_pkg::t_result          o_head,
    output logic                      o_valid,
    output logic [scv_pkg::CNT_W-1:0] o_count
);

    scv_pkg::t_result            r_mem [scv_pkg::FIFO_DEPTH];
    logic [scv_pkg::PTR_W-1:0]   r_wr_ptr;
    logic [scv_pkg::PTR_W-1:0]   r_rd_ptr;
    logic [scv_pkg::CNT_W-1:0]   r_count;
    logic [scv_pkg::CNT_W-1:0]   n_count;
    logic [scv_pkg::PTR_W-1:0]   n_wr_ptr;
    logic [scv_pkg::PTR_W-1:0]   wr_ptr_1;

    assign wr_ptr_1 = r_wr_ptr + scv_pkg::PTR_W'(1);

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_ptr_1] <= i_push.r1;
        end
    end

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (i_push.v1) begin
            n_wr_ptr = r_wr_ptr + scv_pkg::PTR_W'(2);
            n_count  = n_count + scv_pkg::CNT_W'(2);
        end else if (i_push.v0) begin
            n_wr_ptr = wr_ptr_1;
            n_count  = n_count + scv_pkg::CNT_W'(1);
        end
        if (i_pop) begin
            n_count = n_count - scv_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + scv_pkg::PTR_W'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

// ----- rtl/core/sharpen_convolution_3x3.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sharpen_convolution_3x3
// 3x3 sharpening filter over a raster pixel stream, with line buffers,
// border pass-through and a clamped result per interior pixel.
// ============================================================================
//  channel  dir  handshake      payload
//  -------  ---  -------------  ---------------------------------------------
//  i_cfg    in   valid/ready    addr (register), data (11 bits)
//  i_pix    in   valid/ready    pixel_in (8 bits)
//  o_res    out  valid/ready    pixel_out, out_col, out_row, last_of_step
//
//  One pixel is accepted per cycle while input ready is high; results leave
//  the queue one per cycle while the output is ready, so a pixel that yields
//  two results sends them one after the other. Each pixel takes the line
//  buffer read into stage 1, then the window shift, mask sum and clamp into the result queue.
//  Input ready drops unless the eight-entry queue, after reserving two slots
//  for the item in stage 1, still has room for two more results.
//  Synchronous active-low reset clears the counters, window and queue; the
//  line buffers are not cleared; no interior result uses them before a write.
// ============================================================================
module sharpen_convolution_3x3 (
    input logic       i_clk,
    input logic       i_rst_n,
    scv_cfg_if.sink   i_cfg,
    scv_pix_if.sink   i_pix,
    scv_res_if.source o_res
);

    // configuration
    scv_pkg::t_mask                r_mask;
    logic [scv_pkg::SIZE_W-1:0]    r_frame_w;
    logic [scv_pkg::SIZE_W-1:0]    r_frame_h;
    scv_pkg::t_cfg_reg             cfg_reg;
    logic                          cfg_wr;
    logic [scv_pkg::SIZE_W-1:0]    eff_w;
    logic [scv_pkg::SIZE_W-1:0]    eff_h;

    // position of the next pixel
    logic [scv_pkg::COL_W-1:0]     r_col;
    logic [scv_pkg::ROW_W-1:0]     r_row;
    logic [scv_pkg::COL_W-1:0]     n_col;
    logic [scv_pkg::ROW_W-1:0]     n_row;
    logic [scv_pkg::SIZE_W-1:0]    col_inc;
    logic [scv_pkg::SIZE_W-1:0]    row_inc;
    logic                          in_acc;
    logic                          is_inner;
    logic                          is_border;

    // stage 1
    logic                          r_s1_valid;
    logic [scv_pkg::PIX_W-1:0]     r_s1_pix;
    logic [scv_pkg::COL_W-1:0]     r_s1_col;
    logic [scv_pkg::ROW_W-1:0]     r_s1_row;
    logic                          r_s1_inner;
    logic                          r_s1_border;
    scv_pkg::t_line_word           lb_rd;
    scv_pkg::t_line_word           lb_wr;
    scv_pkg::t_window              r_window;
    scv_pkg::t_window              n_window;
    logic [scv_pkg::PIX_W-1:0]     filtered;
    scv_pkg::t_result              res_inner;
    scv_pkg::t_result              res_border;
    scv_pkg::t_push                push;

    // result queue
    scv_pkg::t_result              head;
    logic                          head_valid;
    logic [scv_pkg::CNT_W-1:0]     fifo_count;
    logic                          room;

    // register writes
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign cfg_reg     = scv_pkg::t_cfg_reg'(i_cfg.addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= scv_pkg::MASK_CROSS;
            r_frame_w <= scv_pkg::SIZE_W'(scv_pkg::MAX_WIDTH);
            r_frame_h <= scv_pkg::SIZE_W'(scv_pkg::MAX_HEIGHT);
        end else if (cfg_wr) begin
            case (cfg_reg)
                scv_pkg::REG_MASK:   r_mask    <= scv_pkg::t_mask'(i_cfg.data[1:0]);
                scv_pkg::REG_WIDTH:  r_frame_w <= i_cfg.data;
                scv_pkg::REG_HEIGHT: r_frame_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign eff_w = scv_pkg::eff_size(r_frame_w, scv_pkg::SIZE_W'(scv_pkg::MAX_WIDTH));
    assign eff_h = scv_pkg::eff_size(r_frame_h, scv_pkg::SIZE_W'(scv_pkg::MAX_HEIGHT));

    // input handshake: keep room for two results per item in flight
    assign room = (fifo_count + (r_s1_valid ? scv_pkg::CNT_W'(2) : scv_pkg::CNT_W'(0)))
                  <= scv_pkg::CNT_W'(scv_pkg::FIFO_DEPTH - 2);
    assign i_pix.ready = i_rst_n && room;
    assign in_acc      = i_pix.valid && i_pix.ready;

    // raster position and the classification of the arriving pixel
    always_comb begin
        col_inc   = scv_pkg::SIZE_W'(r_col) + scv_pkg::SIZE_W'(1);
        row_inc   = scv_pkg::SIZE_W'(r_row) + scv_pkg::SIZE_W'(1);
        is_inner  = (r_row >= scv_pkg::ROW_W'(2)) && (r_col >= scv_pkg::COL_W'(2));
        is_border = (r_row == '0) || (r_col == '0) || (row_inc == eff_h) ||
                    (col_inc == eff_w);
        n_col = col_inc[scv_pkg::COL_W-1:0];
        n_row = r_row;
        if (col_inc >= eff_w) begin
            n_col = '0;
            n_row = row_inc[scv_pkg::ROW_W-1:0];
            if (row_inc >= eff_h) begin
                n_row = '0;
            end
        end
    end

    // a size write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr && (cfg_reg == scv_pkg::REG_WIDTH ||
                                cfg_reg == scv_pkg::REG_HEIGHT)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix    <= i_pix.pixel_in;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_inner  <= is_inner;
            r_s1_border <= is_border;
        end
    end

    // line buffer: read at acceptance, write back the shifted column in stage 1
    assign lb_wr.near = r_s1_pix;
    assign lb_wr.far  = lb_rd.near;

    scv_line_buf u_lbuf (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (lb_rd),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (lb_wr)
    );

    // window shift: new column enters on the right
    always_comb begin
        n_window    = r_window;
        n_window[0] = r_window[1];
        n_window[1] = r_window[2];
        n_window[2] = lb_rd.far;
        n_window[3] = r_window[4];
        n_window[4] = r_window[5];
        n_window[5] = lb_rd.near;
        n_window[6] = r_window[7];
        n_window[7] = r_window[8];
        n_window[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (r_s1_valid) begin
            r_window <= n_window;
        end
    end

    assign filtered = scv_pkg::filter_window(n_window, r_mask);

    // results: interior first, border second
    always_comb begin
        res_inner = '{pixel_out:    filtered,
                      out_col:      r_s1_col - scv_pkg::COL_W'(1),
                      out_row:      r_s1_row - scv_pkg::ROW_W'(1),
                      last_of_step: !r_s1_border};
        res_border = '{pixel_out:    r_s1_pix,
                       out_col:      r_s1_col,
                       out_row:      r_s1_row,
                       last_of_step: 1'b1};
        push.v0 = r_s1_valid && (r_s1_inner || r_s1_border);
        push.v1 = r_s1_valid && r_s1_inner && r_s1_border;
        push.r0 = r_s1_inner ? res_inner : res_border;
        push.r1 = res_border;
    end

    scv_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_res.valid && o_res.ready),
        .o_head  (head),
        .o_valid (head_valid),
        .o_count (fifo_count)
    );

    assign o_res.valid        = head_valid;
    assign o_res.pixel_out    = head.pixel_out;
    assign o_res.out_col      = head.out_col;
    assign o_res.out_row      = head.out_row;
    assign o_res.last_of_step = head.last_of_step;

endmodule

// ----- rtl/core/scv_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// scv_checker
// Port-level checks for the sharpening convolution block, bound to the top.
// ============================================================================
module scv_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_pix_valid,
    input logic                      i_pix_ready,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input logic                      i_res_last,
    input logic [scv_pkg::PIX_W-1:0] i_res_pixel,
    input logic [scv_pkg::COL_W-1:0] i_res_col,
    input logic [scv_pkg::ROW_W-1:0] i_res_row
);

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // a result showing up from idle was caused by an item accepted earlier
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_pix_valid && i_pix_ready, 2))
        else $error("result without an accepted item");

    // an interior result that is not last is always followed by its border pair
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && !i_res_last) |=> i_res_valid)
        else $error("second result of a pair missing");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_pixel) && $stable(i_res_col) &&
             $stable(i_res_row) && $stable(i_res_last)))
        else $error("stalled result changed");

endmodule

bind sharpen_convolution_3x3 scv_checker u_scv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_last  (o_res.last_of_step),
    .i_res_pixel (o_res.pixel_out),
    .i_res_col   (o_res.out_col),
    .i_res_row   (o_res.out_row)
);
